// ----- hw/rtl/scdc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package scdc_pkg;

    localparam int SCALE_W       = 5;
    localparam int MAX_SCALE_DEF = 28;
    localparam int LIMB_W        = 32;
    localparam int LIMBS         = 3;
    localparam int MANT_W        = LIMB_W * LIMBS;
    localparam int LOW_W         = 64;
    localparam int HIGH_W        = MANT_W - LOW_W;
    localparam int POW_W         = 94;
    localparam int PP_W          = 2 * LIMB_W;
    localparam int ROW_W         = PP_W + 2 * LIMB_W;
    localparam int PART_W        = ROW_W + LIMB_W + 1;
    localparam int SUM_W         = ROW_W + 2 * LIMB_W;
    localparam int PROD_W        = MANT_W + POW_W;
    localparam int STAGES        = 6;

    localparam logic signed [1:0] ORD_GT = 2'sd1;
    localparam logic signed [1:0] ORD_EQ = 2'sd0;
    localparam logic signed [1:0] ORD_LT = -2'sd1;

    // Side information that travels with each operand pair.
    typedef struct packed {
        logic a_scaled;     // the first value has the smaller scale and is multiplied
        logic both_zero;
        logic sign_differ;
        logic a_neg;
    } scdc_ctl_t;

    function automatic logic [POW_W-1:0] pow10(input logic [SCALE_W-1:0] d);
        logic [POW_W-1:0] p;
        case (d)
            5'd0:    p = 94'd1;
            5'd1:    p = 94'd10;
            5'd2:    p = 94'd100;
            5'd3:    p = 94'd1000;
            5'd4:    p = 94'd10000;
            5'd5:    p = 94'd100000;
            5'd6:    p = 94'd1000000;
            5'd7:    p = 94'd10000000;
            5'd8:    p = 94'd100000000;
            5'd9:    p = 94'd1000000000;
            5'd10:   p = 94'd10000000000;
            5'd11:   p = 94'd100000000000;
            5'd12:   p = 94'd1000000000000;
            5'd13:   p = 94'd10000000000000;
            5'd14:   p = 94'd100000000000000;
            5'd15:   p = 94'd1000000000000000;
            5'd16:   p = 94'd10000000000000000;
            5'd17:   p = 94'd100000000000000000;
            5'd18:   p = 94'd1000000000000000000;
            5'd19:   p = 94'd10000000000000000000;
            5'd20:   p = 94'd100000000000000000000;
            5'd21:   p = 94'd1000000000000000000000;
            5'd22:   p = 94'd10000000000000000000000;
            5'd23:   p = 94'd100000000000000000000000;
            5'd24:   p = 94'd1000000000000000000000000;
            5'd25:   p = 94'd10000000000000000000000000;
            5'd26:   p = 94'd100000000000000000000000000;
            5'd27:   p = 94'd1000000000000000000000000000;
            5'd28:   p = 94'd10000000000000000000000000000;
            default: p = '0;
        endcase
        return p;
    endfunction

    function automatic logic [PP_W-1:0] mul32(input logic [LIMB_W-1:0] x,
                                              input logic [LIMB_W-1:0] y);
        return {{LIMB_W{1'b0}}, x} * {{LIMB_W{1'b0}}, y};
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/scdc_align.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scdc_align #(
    parameter int MAX_SCALE = scdc_pkg::MAX_SCALE_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [scdc_pkg::LOW_W-1:0]      a_mantissa_low,
    input  wire logic [scdc_pkg::HIGH_W-1:0]     a_mantissa_high,
    input  wire logic [scdc_pkg::SCALE_W-1:0]    a_scale,
    input  wire logic                            a_negative,
    input  wire logic [scdc_pkg::LOW_W-1:0]      b_mantissa_low,
    input  wire logic [scdc_pkg::HIGH_W-1:0]     b_mantissa_high,
    input  wire logic [scdc_pkg::SCALE_W-1:0]    b_scale,
    input  wire logic                            b_negative,
    output logic      [scdc_pkg::MANT_W-1:0]     src,
    output logic      [scdc_pkg::MANT_W-1:0]     other,
    output logic      [scdc_pkg::SCALE_W-1:0]    diff,
    output scdc_pkg::scdc_ctl_t                  ctl
);
    import scdc_pkg::*;

    localparam logic [SCALE_W-1:0] SCALE_LIM = SCALE_W'(MAX_SCALE);

    logic [MANT_W-1:0]  a_mant, b_mant;
    logic [SCALE_W-1:0] sa, sb;
    logic [MANT_W-1:0]  src_reg, src_next, other_reg, other_next;
    logic [SCALE_W-1:0] diff_reg, diff_next;
    scdc_ctl_t          ctl_reg, ctl_next;

    always_comb
    begin
        a_mant = {a_mantissa_high, a_mantissa_low};
        b_mant = {b_mantissa_high, b_mantissa_low};
        sa = (a_scale > SCALE_LIM) ? SCALE_LIM : a_scale;
        sb = (b_scale > SCALE_LIM) ? SCALE_LIM : b_scale;

        ctl_next.a_scaled    = (sa < sb);
        ctl_next.both_zero   = (a_mant == '0) && (b_mant == '0);
        ctl_next.sign_differ = a_negative ^ b_negative;
        ctl_next.a_neg       = a_negative;

        // The value with the smaller scale is the one multiplied up.
        if (ctl_next.a_scaled)
        begin
            src_next   = a_mant;
            other_next = b_mant;
            diff_next  = sb - sa;
        end
        else
        begin
            src_next   = b_mant;
            other_next = a_mant;
            diff_next  = sa - sb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            src_reg   <= src_next;
            other_reg <= other_next;
            diff_reg  <= diff_next;
            ctl_reg   <= ctl_next;
        end
    end

    assign src   = src_reg;
    assign other = other_reg;
    assign diff  = diff_reg;
    assign ctl   = ctl_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/scdc_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scdc_mul (
    input  wire logic                            clk,
    input  wire logic [3:0]                      en,
    input  wire logic [scdc_pkg::MANT_W-1:0]     src,
    input  wire logic [scdc_pkg::MANT_W-1:0]     other_in,
    input  wire logic [scdc_pkg::SCALE_W-1:0]    diff,
    input  scdc_pkg::scdc_ctl_t                  ctl_in,
    output logic      [scdc_pkg::PROD_W-1:0]     prod,
    output logic      [scdc_pkg::MANT_W-1:0]     other_out,
    output scdc_pkg::scdc_ctl_t                  ctl_out
);
    import scdc_pkg::*;

    // Stage A: nine 32x32 partial products.
    logic [MANT_W-1:0] pw;
    logic [PP_W-1:0]   pp_reg  [LIMBS][LIMBS];
    logic [PP_W-1:0]   pp_next [LIMBS][LIMBS];
    logic [MANT_W-1:0] other_a_reg;
    scdc_ctl_t         ctl_a_reg;

    // Stage B: one row per source limb.
    logic [ROW_W-1:0]  row_reg  [LIMBS];
    logic [ROW_W-1:0]  row_next [LIMBS];
    logic [MANT_W-1:0] other_b_reg;
    scdc_ctl_t         ctl_b_reg;

    // Stage C: first two rows merged.
    logic [PART_W-1:0] part_reg, part_next;
    logic [ROW_W-1:0]  row2_reg;
    logic [MANT_W-1:0] other_c_reg;
    scdc_ctl_t         ctl_c_reg;

    // Stage D: full product.
    logic [SUM_W-1:0]  sum_full;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [MANT_W-1:0] other_d_reg;
    scdc_ctl_t         ctl_d_reg;

    always_comb
    begin
        pw = {{(MANT_W-POW_W){1'b0}}, pow10(diff)};
        for (int i = 0; i < LIMBS; i++)
        begin
            for (int j = 0; j < LIMBS; j++)
            begin
                pp_next[i][j] = mul32(src[i*LIMB_W +: LIMB_W], pw[j*LIMB_W +: LIMB_W]);
            end
        end
    end

    // The outer partial products of a row do not overlap, so they concatenate.
    always_comb
    begin
        for (int i = 0; i < LIMBS; i++)
        begin
            row_next[i] = {pp_reg[i][2], pp_reg[i][0]}
                        + {{LIMB_W{1'b0}}, pp_reg[i][1], {LIMB_W{1'b0}}};
        end
    end

    assign part_next = {{(PART_W-ROW_W){1'b0}}, row_reg[0]}
                     + {1'b0, row_reg[1], {LIMB_W{1'b0}}};

    assign sum_full  = {{(SUM_W-PART_W){1'b0}}, part_reg}
                     + {row2_reg, {(2*LIMB_W){1'b0}}};
    assign prod_next = sum_full[PROD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pp_reg      <= pp_next;
            other_a_reg <= other_in;
            ctl_a_reg   <= ctl_in;
        end
        if (en[1])
        begin
            row_reg     <= row_next;
            other_b_reg <= other_a_reg;
            ctl_b_reg   <= ctl_a_reg;
        end
        if (en[2])
        begin
            part_reg    <= part_next;
            row2_reg    <= row_reg[2];
            other_c_reg <= other_b_reg;
            ctl_c_reg   <= ctl_b_reg;
        end
        if (en[3])
        begin
            prod_reg    <= prod_next;
            other_d_reg <= other_c_reg;
            ctl_d_reg   <= ctl_c_reg;
        end
    end

    assign prod      = prod_reg;
    assign other_out = other_d_reg;
    assign ctl_out   = ctl_d_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/scdc_cmp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scdc_cmp (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [scdc_pkg::PROD_W-1:0]     prod,
    input  wire logic [scdc_pkg::MANT_W-1:0]     other,
    input  scdc_pkg::scdc_ctl_t                  ctl,
    output logic signed [1:0]                    order,
    output logic                                 is_less,
    output logic                                 is_less_or_equal,
    output logic                                 is_greater,
    output logic                                 is_greater_or_equal,
    output logic                                 is_equal,
    output logic                                 is_not_equal
);
    import scdc_pkg::*;

    logic [PROD_W-1:0] other_ext, a_mag, b_mag;
    logic              mag_eq, mag_gt;
    logic signed [1:0] ord_reg, ord_next;

    always_comb
    begin
        other_ext = {{(PROD_W-MANT_W){1'b0}}, other};
        a_mag     = ctl.a_scaled ? prod : other_ext;
        b_mag     = ctl.a_scaled ? other_ext : prod;
        mag_eq    = (a_mag == b_mag);
        mag_gt    = (a_mag > b_mag);

        if (ctl.both_zero)
        begin
            ord_next = ORD_EQ;
        end
        else if (ctl.sign_differ)
        begin
            ord_next = ctl.a_neg ? ORD_LT : ORD_GT;
        end
        else if (mag_eq)
        begin
            ord_next = ORD_EQ;
        end
        else
        begin
            // Two negatives order opposite to their magnitudes.
            ord_next = (mag_gt ^ ctl.a_neg) ? ORD_GT : ORD_LT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ord_reg <= ord_next;
        end
    end

    assign order               = ord_reg;
    assign is_less             = (ord_reg == ORD_LT);
    assign is_less_or_equal    = (ord_reg != ORD_GT);
    assign is_greater          = (ord_reg == ORD_GT);
    assign is_greater_or_equal = (ord_reg != ORD_LT);
    assign is_equal            = (ord_reg == ORD_EQ);
    assign is_not_equal        = (ord_reg != ORD_EQ);

endmodule

`default_nettype wire

// ----- hw/rtl/scaled_decimal_compare.sv -----
// Each operand pair is registered in the align stage, the multiply stages and the compare stage in turn.
// Throughput: one operand pair per cycle while the output side is ready; the scale-align multiplier
// splits its 96 x 94 bit product into 32 x 32 partial products summed over three stages.
// Reset: rst_n clears every stage valid bit asynchronously; the data registers hold no reset.
// A stage loads whenever it is empty or the stage after it moves, so bubbles close up.
`timescale 1ns / 1ps
`default_nettype none

module scaled_decimal_compare #(
    parameter int MAX_SCALE = scdc_pkg::MAX_SCALE_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [scdc_pkg::LOW_W-1:0]      a_mantissa_low,
    input  wire logic [scdc_pkg::HIGH_W-1:0]     a_mantissa_high,
    input  wire logic [scdc_pkg::SCALE_W-1:0]    a_scale,
    input  wire logic                            a_negative,
    input  wire logic [scdc_pkg::LOW_W-1:0]      b_mantissa_low,
    input  wire logic [scdc_pkg::HIGH_W-1:0]     b_mantissa_high,
    input  wire logic [scdc_pkg::SCALE_W-1:0]    b_scale,
    input  wire logic                            b_negative,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [1:0]                    order,
    output logic                                 is_less,
    output logic                                 is_less_or_equal,
    output logic                                 is_greater,
    output logic                                 is_greater_or_equal,
    output logic                                 is_equal,
    output logic                                 is_not_equal
);
    import scdc_pkg::*;

    // One valid bit per register stage. Stage 0 is the align stage, stages 1 to 4
    // build the product, stage 5 holds the finished result.
    logic [STAGES-1:0] valid_reg, valid_next;
    logic [STAGES-1:0] stage_ready;
    logic [STAGES-1:0] valid_prev;

    logic [MANT_W-1:0]  al_src, al_other, mul_other;
    logic [SCALE_W-1:0] al_diff;
    logic [PROD_W-1:0]  mul_prod;
    scdc_ctl_t          al_ctl, mul_ctl;

    // A stage can take new data when it is empty or its content moves on in the
    // same cycle. The last stage moves when the downstream side takes the transfer.
    always_comb
    begin
        stage_ready[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    always_comb
    begin
        valid_prev = {valid_reg[STAGES-2:0], in_valid};
        valid_next = valid_reg;
        for (int k = 0; k < STAGES; k++)
        begin
            if (stage_ready[k])
            begin
                valid_next[k] = valid_prev[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[STAGES-1];

    // Clamp the scales, flag zeros and signs, and pick the operand to scale up.
    scdc_align #(
        .MAX_SCALE (MAX_SCALE)
    ) u_align (
        .clk             (clk),
        .en              (stage_ready[0]),
        .a_mantissa_low  (a_mantissa_low),
        .a_mantissa_high (a_mantissa_high),
        .a_scale         (a_scale),
        .a_negative      (a_negative),
        .b_mantissa_low  (b_mantissa_low),
        .b_mantissa_high (b_mantissa_high),
        .b_scale         (b_scale),
        .b_negative      (b_negative),
        .src             (al_src),
        .other           (al_other),
        .diff            (al_diff),
        .ctl             (al_ctl)
    );

    // Multiply by the power of ten for the scale difference.
    scdc_mul u_mul (
        .clk       (clk),
        .en        (stage_ready[4:1]),
        .src       (al_src),
        .other_in  (al_other),
        .diff      (al_diff),
        .ctl_in    (al_ctl),
        .prod      (mul_prod),
        .other_out (mul_other),
        .ctl_out   (mul_ctl)
    );

    // Compare the aligned magnitudes and register the order.
    scdc_cmp u_cmp (
        .clk                 (clk),
        .en                  (stage_ready[STAGES-1]),
        .prod                (mul_prod),
        .other               (mul_other),
        .ctl                 (mul_ctl),
        .order               (order),
        .is_less             (is_less),
        .is_less_or_equal    (is_less_or_equal),
        .is_greater          (is_greater),
        .is_greater_or_equal (is_greater_or_equal),
        .is_equal            (is_equal),
        .is_not_equal        (is_not_equal)
    );

    // A full pipeline with a stalled output must refuse new input.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((&valid_reg) && !out_ready) |-> !in_ready)
        else $error("input taken while the pipeline is full and stalled");

    // An accepted input always lands in the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg[0])
        else $error("accepted input did not enter the first stage");

    // Exactly one of less, equal and greater holds for a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot({is_less, is_equal, is_greater}))
        else $error("result flags are not exclusive");

endmodule

`default_nettype wire
